### hw/rtl/wcts_pkg.sv
// ----------------------------------------------------------------------------
// Wall column texture sampler package
// Shared widths, codes and parameter defaults of the sampler block.
// ----------------------------------------------------------------------------
package wcts_pkg;

   // Parameter defaults
   localparam int SCREEN_HEIGHT_DEF    = 768;
   localparam int TEXTURE_COUNT_DEF    = 4;
   localparam int TEXTURE_SIDE_MAX_DEF = 64;
   localparam int COLOR_BITS_DEF       = 32;

   // Fixed field widths
   localparam int OPCODE_W  = 2;
   localparam int TEX_SEL_W = 3;
   localparam int COLUMN_W  = 11;
   localparam int HEIGHT_W  = 16;
   localparam int FRAC_W    = 16;
   localparam int LOAD_W    = 6;
   localparam int PIXEL_W   = 32;
   localparam int ROW_OUT_W = 10;
   localparam int POS_W     = 32;
   localparam int HALF_W    = HEIGHT_W - 1;

   // Configuration port
   localparam int CSR_INDEX_W = 4;
   localparam int CFG_W       = 7;
   localparam int CFG_TEX     = 4;
   localparam int CFG_RESET   = 64;

   typedef enum logic [OPCODE_W-1:0] {
      OP_LOAD  = 2'd0,
      OP_START = 2'd1,
      OP_NEXT  = 2'd2
   } opcode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NORTH_WIDTH  = 4'd0,
      CSR_NORTH_HEIGHT = 4'd1,
      CSR_SOUTH_WIDTH  = 4'd2,
      CSR_SOUTH_HEIGHT = 4'd3,
      CSR_EAST_WIDTH   = 4'd4,
      CSR_EAST_HEIGHT  = 4'd5,
      CSR_WEST_WIDTH   = 4'd6,
      CSR_WEST_HEIGHT  = 4'd7
   } csr_index_type;

   // Command strobes toward the texel memory
   typedef struct packed {
      logic en;
      logic we;
   } mem_ctl_type;

endpackage

### hw/rtl/wcts_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Carries load, start-column and next-row beats into the sampler.
// ----------------------------------------------------------------------------
interface wcts_req_if import wcts_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [OPCODE_W-1:0]  opcode;
   logic [TEX_SEL_W-1:0] texture_select;
   logic [COLUMN_W-1:0]  screen_column;
   logic [HEIGHT_W-1:0]  wall_span;
   logic [FRAC_W-1:0]    wall_fraction;
   logic [LOAD_W-1:0]    load_x;
   logic [LOAD_W-1:0]    load_y;
   logic [PIXEL_W-1:0]   load_color;

   modport source (
      output valid, opcode, texture_select, screen_column, wall_span,
             wall_fraction, load_x, load_y, load_color,
      input  ready
   );

   modport sink (
      input  valid, opcode, texture_select, screen_column, wall_span,
             wall_fraction, load_x, load_y, load_color,
      output ready
   );
endinterface

### hw/rtl/wcts_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Carries one sampled wall pixel per beat out of the sampler.
// ----------------------------------------------------------------------------
interface wcts_rsp_if import wcts_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [COLUMN_W-1:0]  column_out;
   logic [ROW_OUT_W-1:0] row_out;
   logic [PIXEL_W-1:0]   pixel_color;
   logic                 last_row;

   modport source (
      output valid, column_out, row_out, pixel_color, last_row,
      input  ready
   );

   modport sink (
      input  valid, column_out, row_out, pixel_color, last_row,
      output ready
   );
endinterface

### hw/rtl/wcts_csr_if.sv
// ----------------------------------------------------------------------------
// Register write channel
// Carries texture size register writes into the sampler.
// ----------------------------------------------------------------------------
interface wcts_csr_if import wcts_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CFG_W-1:0]       data;

   modport source (
      output valid, index, data,
      input  ready
   );

   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

### hw/rtl/wcts_texel_mem.sv
// ----------------------------------------------------------------------------
// Texel memory
// Single-port synchronous store of all texture texels, registered read data.
// ----------------------------------------------------------------------------
module wcts_texel_mem import wcts_pkg::*; #(
   parameter int DEPTH  = TEXTURE_COUNT_DEF * TEXTURE_SIDE_MAX_DEF * TEXTURE_SIDE_MAX_DEF,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   parameter int DATA_W = COLOR_BITS_DEF
) (
   input  logic              clock,
   input  mem_ctl_type       ctl,
   input  logic [ADDR_W-1:0] addr,
   input  logic [DATA_W-1:0] wdata,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] store_ff [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   // One access per cycle: a write, or a read whose data holds until the next read.
   always_ff @(posedge clock) begin
      if (ctl.en) begin
         if (ctl.we) begin
            store_ff[addr] <= wdata;
         end else begin
            rdata_ff <= store_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/wcts_step_div.sv
// ----------------------------------------------------------------------------
// Row step divider
// Restoring divider, one quotient bit per cycle, for the texture row step.
// ----------------------------------------------------------------------------
module wcts_step_div import wcts_pkg::*; #(
   parameter int DIVIDEND_W = 23
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [HEIGHT_W-1:0]   divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [HEIGHT_W-1:0]   rem_ff, rem_in;
   logic [HEIGHT_W-1:0]   divisor_ff, divisor_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [HEIGHT_W:0]     trial;

   // Shift the next dividend bit into the remainder and try a subtract.
   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      quo_in     = quo_ff;
      trial      = {rem_ff, quo_ff[DIVIDEND_W-1]};

      if (start) begin
         busy_in    = 1'b1;
         count_in   = CNT_W'(DIVIDEND_W);
         rem_in     = '0;
         divisor_in = divisor;
         quo_in     = dividend;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor_ff}) begin
            rem_in = HEIGHT_W'(trial - {1'b0, divisor_ff});
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = trial[HEIGHT_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      quo_ff     <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### hw/rtl/wall_column_texture_sampler.sv
// ----------------------------------------------------------------------------
// Wall column texture sampler
// A next-row beat's pixel passes the read stage, then the output register; load and
// next-row beats are taken one per cycle while idle and while the response side
// does not stall, the texel memory port sets that rate. A start-column beat holds
// the request side while the step divider works, one quotient bit per cycle, then
// while the sequencer takes the quotient and scales the start position.
// Reset clears the sequencer, the column state but the clip offset, and the size
// registers (to 64); the texel memory is not cleared and holds garbage until loaded.
// ----------------------------------------------------------------------------
module wall_column_texture_sampler import wcts_pkg::*; #(
   parameter int SCREEN_HEIGHT    = SCREEN_HEIGHT_DEF,
   parameter int TEXTURE_COUNT    = TEXTURE_COUNT_DEF,
   parameter int TEXTURE_SIDE_MAX = TEXTURE_SIDE_MAX_DEF,
   parameter int COLOR_BITS       = COLOR_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   wcts_req_if.sink   req_if,
   wcts_rsp_if.source rsp_if,
   wcts_csr_if.sink   csr_if
);

   localparam int MID_ROW     = SCREEN_HEIGHT / 2;
   localparam int ROW_W       = $clog2(SCREEN_HEIGHT + 1);
   localparam int SW          = $clog2(TEXTURE_SIDE_MAX + 1);
   localparam int CW          = (TEXTURE_SIDE_MAX > 1) ? $clog2(TEXTURE_SIDE_MAX) : 1;
   localparam int TEX_W       = (TEXTURE_COUNT > 1) ? $clog2(TEXTURE_COUNT) : 1;
   localparam int SIDE_SQ     = TEXTURE_SIDE_MAX * TEXTURE_SIDE_MAX;
   localparam int STORE_DEPTH = TEXTURE_COUNT * SIDE_SQ;
   localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int DIV_W       = SW + FRAC_W;
   localparam int PROD_W      = HALF_W + DIV_W;
   localparam int CMP_W       = LOAD_W + 1;
   localparam int CFG_SEL_W   = $clog2(CFG_TEX);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SCALE
   } state_type;

   // Register value used as a side length: zero reads as one, large values clamp.
   function automatic logic [SW-1:0] side_clamp(input logic [CFG_W-1:0] v);
      logic [SW-1:0] r;
      if (v == '0) begin
         r = SW'(1);
      end else if (v > CFG_W'(TEXTURE_SIDE_MAX)) begin
         r = SW'(TEXTURE_SIDE_MAX);
      end else begin
         r = SW'(v);
      end
      return r;
   endfunction

   // Texel address: texture-major, then row, then column.
   function automatic logic [AW-1:0] texel_addr(input logic [TEX_W-1:0] t,
                                                input logic [CW-1:0]    y,
                                                input logic [CW-1:0]    x);
      return AW'(AW'(t) * AW'(SIDE_SQ)) + AW'(AW'(y) * AW'(TEXTURE_SIDE_MAX)) + AW'(x);
   endfunction

   // Sequencer and column state
   state_type            state_ff, state_in;
   logic [ROW_W-1:0]     cur_row_ff, cur_row_in;
   logic [ROW_W-1:0]     end_row_ff, end_row_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [POS_W-1:0]     step_ff, step_in;
   logic [CW-1:0]        texel_x_ff, texel_x_in;
   logic [TEX_W-1:0]     act_tex_ff, act_tex_in;
   logic [COLUMN_W-1:0]  act_col_ff, act_col_in;
   logic [HALF_W-1:0]    offset_ff, offset_in;

   // Size registers
   logic [CFG_W-1:0]     width_ff [CFG_TEX];
   logic [CFG_W-1:0]     width_in [CFG_TEX];
   logic [CFG_W-1:0]     height_ff [CFG_TEX];
   logic [CFG_W-1:0]     height_in [CFG_TEX];

   // Read stage (memory access in flight) and output register
   logic                 rd_valid_ff, rd_valid_in;
   logic [COLUMN_W-1:0]  rd_column_ff, rd_column_in;
   logic [ROW_OUT_W-1:0] rd_row_ff, rd_row_in;
   logic                 rd_last_ff, rd_last_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [COLUMN_W-1:0]  rsp_column_ff, rsp_column_in;
   logic [ROW_OUT_W-1:0] rsp_row_ff, rsp_row_in;
   logic [PIXEL_W-1:0]   rsp_pixel_ff, rsp_pixel_in;
   logic                 rsp_last_ff, rsp_last_in;

   // Memory and divider hookup
   mem_ctl_type          mem_ctl;
   logic [AW-1:0]        mem_addr;
   logic [COLOR_BITS-1:0] mem_wdata;
   logic [COLOR_BITS-1:0] mem_rdata;
   logic                 div_start;
   logic                 div_done;
   logic [DIV_W-1:0]     div_quotient;

   // Request decode
   logic                 req_accept;
   logic                 advance;
   logic [TEX_W-1:0]     sel_tex;
   logic [CFG_SEL_W-1:0] h_sel;
   logic [SW-1:0]        w_side;
   logic [SW-1:0]        h_side;
   logic [HALF_W-1:0]    half;
   logic [ROW_W-1:0]     top_row;
   logic [ROW_W-1:0]     bot_row;
   logic [HEIGHT_W-1:0]  bot_sum;
   logic [SW+FRAC_W-1:0] tx_prod;
   logic [SW-1:0]        tx_raw;
   logic [SW-1:0]        w_last;
   logic [HEIGHT_W-1:0]  h_last;
   logic [HEIGHT_W-1:0]  ty_full;
   logic [POS_W:0]       pos_sum;
   logic [PROD_W-1:0]    scale_prod;
   logic [63:0]          scale_wide;
   logic                 load_in_range;
   logic [ROW_W:0]       next_row;

   assign advance    = !rsp_valid_ff || rsp_if.ready;
   assign req_accept = req_if.valid && req_if.ready;
   assign sel_tex    = (req_if.texture_select < TEX_SEL_W'(TEXTURE_COUNT)) ?
                       TEX_W'(req_if.texture_select) : '0;

   // Width is read only for a start beat; height at one address, chosen by the opcode.
   assign h_sel  = (req_if.opcode == OP_START) ? CFG_SEL_W'(sel_tex) : CFG_SEL_W'(act_tex_ff);
   assign w_side = side_clamp(width_ff[CFG_SEL_W'(sel_tex)]);
   assign h_side = side_clamp(height_ff[h_sel]);

   // Column geometry for a start beat
   assign half    = req_if.wall_span[HEIGHT_W-1:1];
   assign top_row = (half >= HALF_W'(MID_ROW)) ? '0 : ROW_W'(HALF_W'(MID_ROW) - half);
   assign bot_sum = HEIGHT_W'(half) + HEIGHT_W'(MID_ROW);
   assign bot_row = (bot_sum > HEIGHT_W'(SCREEN_HEIGHT)) ? ROW_W'(SCREEN_HEIGHT) :
                    ROW_W'(bot_sum);
   assign tx_prod = (SW+FRAC_W)'(req_if.wall_fraction) * (SW+FRAC_W)'(w_side);
   assign tx_raw  = tx_prod[SW+FRAC_W-1:FRAC_W];
   assign w_last  = w_side - SW'(1);

   // Texture row for a next-row beat, and the saturating position advance
   assign h_last  = HEIGHT_W'(h_side) - HEIGHT_W'(1);
   assign ty_full = (pos_ff[POS_W-1:FRAC_W] > h_last) ? h_last : pos_ff[POS_W-1:FRAC_W];
   assign pos_sum = {1'b0, pos_ff} + {1'b0, step_ff};
   assign next_row = {1'b0, cur_row_ff} + (ROW_W+1)'(1);

   // Start position: rows clipped off the top times the step, saturated to 32 bits.
   assign scale_prod = PROD_W'(offset_ff) * PROD_W'(step_ff[DIV_W-1:0]);
   assign scale_wide = 64'(scale_prod);

   assign load_in_range = (CMP_W'(req_if.load_x) < CMP_W'(TEXTURE_SIDE_MAX)) &&
                          (CMP_W'(req_if.load_y) < CMP_W'(TEXTURE_SIDE_MAX));

   assign req_if.ready = (state_ff == ST_IDLE) && (!rd_valid_ff || advance);
   assign csr_if.ready = 1'b1;

   // Next-state logic for the sequencer, the pipeline and the size registers
   always_comb begin
      state_in      = state_ff;
      cur_row_in    = cur_row_ff;
      end_row_in    = end_row_ff;
      pos_in        = pos_ff;
      step_in       = step_ff;
      texel_x_in    = texel_x_ff;
      act_tex_in    = act_tex_ff;
      act_col_in    = act_col_ff;
      offset_in     = offset_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      rd_valid_in   = rd_valid_ff;
      rd_column_in  = rd_column_ff;
      rd_row_in     = rd_row_ff;
      rd_last_in    = rd_last_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_column_in = rsp_column_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_pixel_in  = rsp_pixel_ff;
      rsp_last_in   = rsp_last_ff;
      mem_ctl       = '0;
      mem_addr      = texel_addr(act_tex_ff, CW'(ty_full), texel_x_ff);
      mem_wdata     = req_if.load_color[COLOR_BITS-1:0];
      div_start     = 1'b0;

      // Register writes
      if (csr_if.valid) begin
         case (csr_if.index)
            CSR_NORTH_WIDTH:  width_in[0]  = csr_if.data;
            CSR_NORTH_HEIGHT: height_in[0] = csr_if.data;
            CSR_SOUTH_WIDTH:  width_in[1]  = csr_if.data;
            CSR_SOUTH_HEIGHT: height_in[1] = csr_if.data;
            CSR_EAST_WIDTH:   width_in[2]  = csr_if.data;
            CSR_EAST_HEIGHT:  height_in[2] = csr_if.data;
            CSR_WEST_WIDTH:   width_in[3]  = csr_if.data;
            CSR_WEST_HEIGHT:  height_in[3] = csr_if.data;
            default: ;
         endcase
      end

      // Move the read stage into the output register when it is free.
      if (advance) begin
         rsp_valid_in = rd_valid_ff;
         if (rd_valid_ff) begin
            rsp_column_in = rd_column_ff;
            rsp_row_in    = rd_row_ff;
            rsp_pixel_in  = PIXEL_W'(mem_rdata);
            rsp_last_in   = rd_last_ff;
         end
         rd_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_if.opcode)
                  OP_LOAD: begin
                     mem_ctl.en = load_in_range;
                     mem_ctl.we = 1'b1;
                     mem_addr   = texel_addr(sel_tex, CW'(req_if.load_y), CW'(req_if.load_x));
                  end
                  OP_START: begin
                     texel_x_in = CW'((tx_raw > w_last) ? w_last : tx_raw);
                     act_tex_in = sel_tex;
                     act_col_in = req_if.screen_column;
                     cur_row_in = top_row;
                     offset_in  = (half >= HALF_W'(MID_ROW)) ? half - HALF_W'(MID_ROW) : '0;
                     // A zero height has no divide and an empty column.
                     if (req_if.wall_span == '0) begin
                        end_row_in = top_row;
                        step_in    = '0;
                        pos_in     = '0;
                     end else begin
                        end_row_in = bot_row;
                        div_start  = 1'b1;
                        state_in   = ST_DIVIDE;
                     end
                  end
                  OP_NEXT: begin
                     if (cur_row_ff < end_row_ff) begin
                        mem_ctl.en   = 1'b1;
                        mem_ctl.we   = 1'b0;
                        pos_in       = pos_sum[POS_W] ? '1 : pos_sum[POS_W-1:0];
                        rd_valid_in  = 1'b1;
                        rd_column_in = act_col_ff;
                        rd_row_in    = ROW_OUT_W'(cur_row_ff);
                        rd_last_in   = (next_row == {1'b0, end_row_ff});
                        cur_row_in   = next_row[ROW_W-1:0];
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               step_in  = POS_W'(div_quotient);
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            pos_in   = (scale_wide > 64'(32'hFFFF_FFFF)) ? '1 : scale_wide[POS_W-1:0];
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_row_ff   <= '0;
         end_row_ff   <= '0;
         pos_ff       <= '0;
         step_ff      <= '0;
         texel_x_ff   <= '0;
         act_tex_ff   <= '0;
         act_col_ff   <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CFG_TEX; i++) begin
            width_ff[i]  <= CFG_W'(CFG_RESET);
            height_ff[i] <= CFG_W'(CFG_RESET);
         end
      end else begin
         state_ff     <= state_in;
         cur_row_ff   <= cur_row_in;
         end_row_ff   <= end_row_in;
         pos_ff       <= pos_in;
         step_ff      <= step_in;
         texel_x_ff   <= texel_x_in;
         act_tex_ff   <= act_tex_in;
         act_col_ff   <= act_col_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
      end
      offset_ff     <= offset_in;
      rd_column_ff  <= rd_column_in;
      rd_row_ff     <= rd_row_in;
      rd_last_ff    <= rd_last_in;
      rsp_column_ff <= rsp_column_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_pixel_ff  <= rsp_pixel_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.column_out  = rsp_column_ff;
   assign rsp_if.row_out     = rsp_row_ff;
   assign rsp_if.pixel_color = rsp_pixel_ff;
   assign rsp_if.last_row    = rsp_last_ff;

   // Texel store
   wcts_texel_mem #(
      .DEPTH  (STORE_DEPTH),
      .ADDR_W (AW),
      .DATA_W (COLOR_BITS)
   ) u_texel_mem (
      .clock (clock),
      .ctl   (mem_ctl),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   // Row step: (height << 16) / wall height
   wcts_step_div #(
      .DIVIDEND_W (DIV_W)
   ) u_step_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({h_side, FRAC_W'(0)}),
      .divisor  (req_if.wall_span),
      .done     (div_done),
      .quotient (div_quotient)
   );

endmodule
